// ----- rtl/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// Trial division prime test: shared package
// Field widths, the first trial divisor and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int unsigned CAND_W        = 32;
    localparam int unsigned TALLY_W       = 32;
    localparam int unsigned FIRST_DIVISOR = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture the accepted word and set the first divisor
        logic start_div;  // clear the partial remainder, point at the top bit
        logic div_step;   // one restoring remainder step
        logic next_div;   // advance to the next trial divisor
        logic emit;       // load the result register and update the tally
        logic prime;      // verdict that goes with emit
    } tdp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_small;    // candidate below the first divisor
        logic sq_over;    // divisor squared exceeds the candidate
        logic bit_zero;   // the current step shifts in the lowest bit
        logic rem_zero;   // the divisor leaves no remainder
        logic out_free;   // the result register can take a word this cycle
    } tdp_status_t;

endpackage

// ----- rtl/tdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Trial division prime test: controller
// Sequences the divisor loop: compare divisor squared, run one remainder
// pass, evaluate, and hand the verdict to the result register.
// ----------------------------------------------------------------------------
module tdp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tdp_pkg::tdp_status_t status,
    output tdp_pkg::tdp_cmd_t    cmd
);
    import tdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EVAL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   prime_reg;

    assign s_tready = ready_reg;

    always_comb begin
        cmd           = '0;
        cmd.prime     = prime_reg;
        cmd.load_in   = (state_reg == ST_IDLE) && s_tvalid && ready_reg;
        cmd.start_div = (state_reg == ST_CHECK) && !status.n_small && !status.sq_over;
        cmd.div_step  = (state_reg == ST_DIVIDE);
        cmd.next_div  = (state_reg == ST_EVAL) && !status.rem_zero;
        cmd.emit      = (state_reg == ST_FINISH) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            prime_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && ready_reg) begin
                        ready_reg <= 1'b0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    // Zero and one are never prime; otherwise stop once d*d > n.
                    if (status.n_small) begin
                        prime_reg <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else if (status.sq_over) begin
                        prime_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (status.bit_zero) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (status.rem_zero) begin
                        prime_reg <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FINISH: begin
                    if (status.out_free) begin
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/tdp_datapath.sv -----
// ----------------------------------------------------------------------------
// Trial division prime test: datapath
// Candidate and divisor registers, a bit-serial restoring remainder unit,
// the prime tally and the result register.
// ----------------------------------------------------------------------------
module tdp_datapath #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tdp_pkg::CAND_W-1:0]    cand_in,
    input  logic                          last_in,
    input  tdp_pkg::tdp_cmd_t             cmd,
    output tdp_pkg::tdp_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tdp_pkg::CAND_W-1:0]    number_out,
    output logic                          prime_out,
    output logic [tdp_pkg::TALLY_W-1:0]   tally_out
);
    import tdp_pkg::*;

    // Candidate width as used, divisor width and divisor-squared width.
    localparam int unsigned NW = (VALUE_BITS < CAND_W) ? VALUE_BITS : CAND_W;
    localparam int unsigned DW = (NW + 1) / 2 + 2;
    localparam int unsigned SW = 2 * DW;
    localparam int unsigned BW = $clog2(NW);

    logic [NW-1:0]      n_reg;
    logic               last_reg;
    logic [DW-1:0]      d_reg;
    logic [SW-1:0]      sq_reg;
    logic [DW-1:0]      rem_reg, rem_next;
    logic [BW-1:0]      bit_reg;
    logic [DW:0]        trial;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               m_valid_reg;
    logic [CAND_W-1:0]  number_reg;
    logic               prime_reg;
    logic [TALLY_W-1:0] count_reg;

    // Shift in the next candidate bit; subtract the divisor when it fits.
    assign trial = {rem_reg, n_reg[bit_reg]};
    always_comb begin
        if (trial >= {1'b0, d_reg}) begin
            rem_next = DW'(trial - {1'b0, d_reg});
        end else begin
            rem_next = trial[DW-1:0];
        end
    end

    always_comb begin
        tally_next = tally_reg;
        if (cmd.prime && (tally_reg != '1)) begin
            tally_next = tally_reg + TALLY_W'(1);
        end
    end

    assign status.n_small  = (n_reg < NW'(FIRST_DIVISOR));
    assign status.sq_over  = (sq_reg > SW'(n_reg));
    assign status.bit_zero = (bit_reg == '0);
    assign status.rem_zero = (rem_reg == '0);
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign number_out = number_reg;
    assign prime_out  = prime_reg;
    assign tally_out  = count_reg;

    // Working registers carry no reset; the controller loads them first.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            n_reg    <= cand_in[NW-1:0];
            last_reg <= last_in;
            d_reg    <= DW'(FIRST_DIVISOR);
            sq_reg   <= SW'(FIRST_DIVISOR * FIRST_DIVISOR);
        end else if (cmd.next_div) begin
            // Two, then odd divisors only: an even factor would have shown at two.
            if (d_reg == DW'(FIRST_DIVISOR)) begin
                d_reg  <= DW'(FIRST_DIVISOR + 1);
                sq_reg <= SW'((FIRST_DIVISOR + 1) * (FIRST_DIVISOR + 1));
            end else begin
                d_reg  <= d_reg + DW'(2);
                sq_reg <= sq_reg + (SW'(d_reg) << 2) + SW'(4);
            end
        end

        if (cmd.start_div) begin
            rem_reg <= '0;
            bit_reg <= BW'(NW - 1);
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            bit_reg <= bit_reg - BW'(1);
        end

        if (cmd.emit) begin
            number_reg <= CAND_W'(n_reg);
            prime_reg  <= cmd.prime;
            count_reg  <= tally_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                tally_reg   <= last_reg ? '0 : tally_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/trial_division_prime_test_core.sv -----
// Candidates whose divisor loop ends at once (0 to 3) go straight to the result; every
// other candidate gets one remainder pass per trial divisor (2, then odd ones up to sqrt(n)).
// The worst case at 32 bits is about 32768 divisors, each pass run by the one-bit-a-cycle
// remainder unit. One word is in work at a time; the next is taken once the
// result register has been loaded, while that result may still wait on m_tready.
// Reset (aresetn low, synchronous) clears the prime tally and empties the output.
// ----------------------------------------------------------------------------
// Trial division prime test: top level
// Tests each candidate word by trial division and reports the verdict with
// the running prime count of the current range.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] candidate
    input  logic        s_tlast,   // last_in_range
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] number, [63:32] primes_in_range
    output logic [0:0]  m_tuser    // [0] is_prime
);
    import tdp_pkg::*;

    tdp_cmd_t           cmd;
    tdp_status_t        status;
    logic [CAND_W-1:0]  number;
    logic               is_prime;
    logic [TALLY_W-1:0] primes_in_range;

    tdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdp_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cand_in    (s_tdata),
        .last_in    (s_tlast),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .number_out (number),
        .prime_out  (is_prime),
        .tally_out  (primes_in_range)
    );

    assign m_tdata = {primes_in_range, number};
    assign m_tuser = is_prime;

endmodule

// ----- rtl/tdp_checker.sv -----
// ----------------------------------------------------------------------------
// Trial division prime test: port checker
// Watches the top-level ports and flags results and handshakes that cannot
// come from a correct design.
// ----------------------------------------------------------------------------
module tdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A result waiting on the sink holds its word.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // One word in work at a time: the input closes right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted a second word while busy");

    // Zero and one are never reported prime.
    a_small_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[31:1] != 31'd0)
        else $error("zero or one reported prime");

    // The only even prime is two.
    a_even_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && !m_tdata[0] |-> m_tdata[31:0] == 32'd2)
        else $error("even number above two reported prime");

endmodule

bind trial_division_prime_test_core tdp_checker u_tdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
